FILE: hw/rtl/assembly_token_lexer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the assembly token lexer
// Shared always, immediate-cycle and next-cycle property forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSEMBLY_TOKEN_LEXER_ASSERT_SVH
`define ASSEMBLY_TOKEN_LEXER_ASSERT_SVH

// expr must hold at every edge outside reset
`define ATL_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("lexer check failed");

// cons must hold in the cycle after ante
`define ATL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lexer check failed");

// cons must hold in the same cycle as ante
`define ATL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lexer check failed");

`endif

FILE: hw/rtl/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Types and constants shared by the assembly token lexer modules.
// ----------------------------------------------------------------------------
package atl_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int TQ_DEPTH          = 4;

	typedef enum logic [3:0] {
		KIND_UNKNOWN = 4'd0,
		KIND_END     = 4'd1,
		KIND_EOL     = 4'd2,
		KIND_COLON   = 4'd3,
		KIND_COMMA   = 4'd4,
		KIND_SEMI    = 4'd5,
		KIND_STRING  = 4'd6,
		KIND_SYMBOL  = 4'd7,
		KIND_BIN     = 4'd8,
		KIND_OCT     = 4'd9,
		KIND_DEC     = 4'd10,
		KIND_HEX     = 4'd11
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_AFTER_EOL = 3'd1,
		MODE_STR_SQ    = 3'd2,
		MODE_STR_DQ    = 3'd3,
		MODE_SYMBOL    = 3'd4,
		MODE_ZERO      = 3'd5,
		MODE_DIGITS    = 3'd6
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic        unclosed;
		logic        last;
	} token_t;

	// tokens produced by one character, 0..2
	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} push_t;

	typedef struct packed {
		logic room;   // space for two more tokens
		logic valid;
	} tq_status_t;

endpackage

FILE: hw/rtl/atl_fifo.sv
// ----------------------------------------------------------------------------
// atl_fifo
// Token queue: takes up to two tokens per cycle, hands out one per beat.
// ----------------------------------------------------------------------------
module atl_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  atl_pkg::push_t  push,
	input  logic            pop,
	output atl_pkg::token_t head,
	output atl_pkg::tq_status_t status
);
	import atl_pkg::*;

	localparam int PtrW = $clog2(TQ_DEPTH);
	localparam int CntW = $clog2(TQ_DEPTH + 1);

	token_t            entries_q [TQ_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_pop;

	assign do_pop       = pop && (count_q != '0);
	assign head         = entries_q[rd_ptr_q];
	assign status.valid = (count_q != '0);
	assign status.room  = (count_q <= CntW'(TQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) entries_q[wr_ptr_q] <= push.tok0;
		if (push.cnt == 2'd2) entries_q[wr_ptr_q + PtrW'(1)] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(push.cnt);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
			count_q <= count_q + CntW'(push.cnt) - CntW'(do_pop);
		end
	end

`include "assembly_token_lexer_assert.svh"

	`ATL_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(TQ_DEPTH))
	`ATL_ASSERT_IMPL(a_no_overflow, push.cnt != 2'd0, count_q <= CntW'(TQ_DEPTH - 2))
	`ATL_ASSERT_NEXT(a_pop_drains, do_pop && push.cnt == 2'd0, count_q == $past(count_q) - CntW'(1))

endmodule

FILE: hw/rtl/atl_lex.sv
// ----------------------------------------------------------------------------
// atl_lex
// Lexer state and per-character decode; emits up to two tokens per beat.
// ----------------------------------------------------------------------------
module atl_lex #(
	parameter int POSITION_BITS = atl_pkg::POSITION_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     character,
	output atl_pkg::push_t push
);
	import atl_pkg::*;

	localparam logic [7:0] ChNl    = 8'h0a;
	localparam logic [7:0] ChCr    = 8'h0d;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChColon = 8'h3a;
	localparam logic [7:0] ChComma = 8'h2c;
	localparam logic [7:0] ChSemi  = 8'h3b;
	localparam logic [7:0] ChUnder = 8'h5f;
	localparam logic [7:0] ChSq    = 8'h27;
	localparam logic [7:0] ChDq    = 8'h22;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);

	typedef logic [POSITION_BITS-1:0] pos_t;

	function automatic pos_t sat_inc(input pos_t v);
		return (v == '1) ? v : v + PosOne;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ChZero) && (c <= ChNine);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c == ChUnder) || (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
	endfunction

	mode_t mode_q, nxt_mode;
	kind_t pkind_q, nxt_pkind;
	pos_t  pstart_q, nxt_pstart;
	pos_t  pline_q, nxt_pline;
	pos_t  pos_q, nxt_pos;
	pos_t  line_q, nxt_line;

	pos_t   pos_inc;
	pos_t   plen;
	logic   str_mode;

	// idle-state decode
	logic   lx_emit;
	token_t lx_tok;
	mode_t  lx_mode;
	logic   lx_pend;
	kind_t  lx_pkind;
	pos_t   lx_pstart;
	logic   lx_nl;

	logic   fl_emit, b_emit, use_idle;
	token_t fl_tok, b_tok;

	assign pos_inc  = sat_inc(pos_q);
	assign plen     = (pos_q >= pstart_q) ? pos_q - pstart_q : '0;
	assign str_mode = (mode_q == MODE_STR_SQ) || (mode_q == MODE_STR_DQ);

	always_comb begin
		lx_mode   = MODE_IDLE;
		lx_emit   = 1'b0;
		lx_pend   = 1'b0;
		lx_pkind  = pkind_q;
		lx_pstart = pstart_q;
		lx_nl     = 1'b0;
		lx_tok    = '{kind: KIND_UNKNOWN, start: 16'(pos_q), length: 16'd1,
		              line: 16'(line_q), unclosed: 1'b0, last: 1'b0};
		if (character == ChSpace || character == ChTab) begin
			lx_emit = 1'b0;
		end else if (character == ChNl) begin
			lx_emit     = 1'b1;
			lx_tok.kind = KIND_EOL;
			lx_nl       = 1'b1;
			lx_mode     = MODE_AFTER_EOL;
		end else if (character == ChColon) begin
			lx_emit     = 1'b1;
			lx_tok.kind = KIND_COLON;
		end else if (character == ChComma) begin
			lx_emit     = 1'b1;
			lx_tok.kind = KIND_COMMA;
		end else if (character == ChSemi) begin
			lx_emit     = 1'b1;
			lx_tok.kind = KIND_SEMI;
		end else begin
			lx_pend = 1'b1;
			if (character == ChSq || character == ChDq) begin
				lx_mode   = (character == ChSq) ? MODE_STR_SQ : MODE_STR_DQ;
				lx_pkind  = KIND_STRING;
				lx_pstart = pos_inc;
			end else if (is_alpha(character)) begin
				lx_mode   = MODE_SYMBOL;
				lx_pkind  = KIND_SYMBOL;
				lx_pstart = pos_q;
			end else if (character == ChZero) begin
				lx_mode   = MODE_ZERO;
				lx_pkind  = KIND_OCT;
				lx_pstart = pos_inc;
			end else if (is_digit(character)) begin
				lx_mode   = MODE_DIGITS;
				lx_pkind  = KIND_DEC;
				lx_pstart = pos_q;
			end else begin
				lx_emit = 1'b1;
			end
		end
	end

	always_comb begin
		nxt_mode   = mode_q;
		nxt_pkind  = pkind_q;
		nxt_pstart = pstart_q;
		nxt_pline  = pline_q;
		nxt_pos    = pos_inc;
		nxt_line   = line_q;
		fl_emit    = 1'b0;
		use_idle   = 1'b0;
		b_emit     = 1'b0;
		fl_tok     = '{kind: pkind_q, start: 16'(pstart_q), length: 16'(plen),
		              line: 16'(pline_q), unclosed: 1'b0, last: 1'b0};
		b_tok      = lx_tok;

		if (character == ChNul) begin
			// flush open token, then end-of-text, then back to reset state
			fl_emit = str_mode || (mode_q == MODE_SYMBOL) || (mode_q == MODE_ZERO)
			          || (mode_q == MODE_DIGITS);
			if (str_mode) begin
				fl_tok.kind     = KIND_STRING;
				fl_tok.unclosed = 1'b1;
			end
			b_emit     = 1'b1;
			b_tok      = '{kind: KIND_END, start: 16'(pos_q), length: 16'd0,
			              line: 16'(line_q), unclosed: 1'b0, last: 1'b0};
			nxt_mode   = MODE_IDLE;
			nxt_pkind  = KIND_UNKNOWN;
			nxt_pstart = '0;
			nxt_pline  = PosOne;
			nxt_pos    = '0;
			nxt_line   = PosOne;
		end else begin
			case (mode_q)
				MODE_AFTER_EOL: begin
					if (character == ChCr) nxt_mode = MODE_IDLE;
					else use_idle = 1'b1;
				end
				MODE_STR_SQ, MODE_STR_DQ: begin
					if (character == ((mode_q == MODE_STR_SQ) ? ChSq : ChDq)) begin
						fl_emit     = 1'b1;
						fl_tok.kind = KIND_STRING;
						nxt_mode    = MODE_IDLE;
					end
				end
				MODE_SYMBOL: begin
					if (!(is_alpha(character) || is_digit(character))) begin
						fl_emit  = 1'b1;
						use_idle = 1'b1;
					end
				end
				MODE_ZERO: begin
					if (character == 8'h62 || character == 8'h42) begin
						nxt_pkind  = KIND_BIN;
						nxt_pstart = pos_inc;
						nxt_mode   = MODE_DIGITS;
					end else if (character == 8'h78 || character == 8'h58) begin
						nxt_pkind  = KIND_HEX;
						nxt_pstart = pos_inc;
						nxt_mode   = MODE_DIGITS;
					end else if (is_digit(character)) begin
						nxt_mode = MODE_DIGITS;
					end else begin
						fl_emit  = 1'b1;
						use_idle = 1'b1;
					end
				end
				MODE_DIGITS: begin
					if (!is_digit(character)) begin
						fl_emit  = 1'b1;
						use_idle = 1'b1;
					end
				end
				default: begin
					use_idle = 1'b1;
				end
			endcase
			if (use_idle) begin
				b_emit   = lx_emit;
				nxt_mode = lx_mode;
				if (lx_pend) begin
					nxt_pkind  = lx_pkind;
					nxt_pstart = lx_pstart;
					nxt_pline  = line_q;
				end
				if (lx_nl) nxt_line = sat_inc(line_q);
			end
		end

		push.cnt       = 2'(fl_emit) + 2'(b_emit);
		push.tok0      = fl_emit ? fl_tok : b_tok;
		push.tok0.last = !(fl_emit && b_emit);
		push.tok1      = b_tok;
		push.tok1.last = 1'b1;
		if (!fire) push.cnt = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pkind_q  <= KIND_UNKNOWN;
			pstart_q <= '0;
			pline_q  <= PosOne;
			pos_q    <= '0;
			line_q   <= PosOne;
		end else if (fire) begin
			mode_q   <= nxt_mode;
			pkind_q  <= nxt_pkind;
			pstart_q <= nxt_pstart;
			pline_q  <= nxt_pline;
			pos_q    <= nxt_pos;
			line_q   <= nxt_line;
		end
	end

`include "assembly_token_lexer_assert.svh"

	`ATL_ASSERT_NEXT(a_eot_restart, fire && character == ChNul, pos_q == '0 && line_q == PosOne && mode_q == MODE_IDLE)
	`ATL_ASSERT_IMPL(a_pair_last, push.cnt == 2'd2, push.tok1.last && !push.tok0.last)
	`ATL_ASSERT_IMPL(a_eot_emits, fire && character == ChNul, push.cnt != 2'd0)

endmodule

FILE: hw/rtl/assembly_token_lexer.sv
// Path: a byte waits in the input register for queue room; its tokens then enter the queue.
// Throughput: one character per cycle while the token queue has room; a character that
// closes a symbol or number and is itself a one-character token, or a byte 0 closing one,
// makes two tokens, two output beats; the four-entry queue sets the rate when output stalls.
// Reset: idle between tokens, offset 0, line 1, queue empty; byte 0 also restarts.
// ----------------------------------------------------------------------------
// assembly_token_lexer
// Streaming lexer for assembly text: one byte in per beat, tokens out.
// ----------------------------------------------------------------------------
module assembly_token_lexer #(
	parameter int POSITION_BITS = atl_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] character
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] token_start, [31:16] token_length, [47:32] line_number,
	// [48] unclosed_string, [55:49] zero
	output logic [55:0] m_axis_tdata,
	output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
	output logic        m_axis_tlast    // last_of_run
);
	import atl_pkg::*;

	logic       s1_valid_q;
	logic [7:0] s1_char_q;
	logic       fire;

	push_t      push;
	token_t     head;
	tq_status_t tq_status;

	assign fire          = s1_valid_q && tq_status.room;
	assign s_axis_tready = !s1_valid_q || tq_status.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) s1_char_q <= s_axis_tdata;
	end

	atl_lex #(
		.POSITION_BITS(POSITION_BITS)
	) u_lex (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.character (s1_char_q),
		.push      (push)
	);

	atl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (m_axis_tready),
		.head   (head),
		.status (tq_status)
	);

	assign m_axis_tvalid = tq_status.valid;
	assign m_axis_tdata  = {7'd0, head.unclosed, head.line, head.length, head.start};
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;

endmodule

FILE: tb/tb_assembly_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_assembly_token_lexer
// Feeds text bytes into the lexer and checks every token beat against a
// shadow lexer kept in the bench or a typed token: a directed table first, then random
// assembly-like text under varying backpressure.
// ----------------------------------------------------------------------------
module tb_assembly_token_lexer;

	import atl_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int MAX_PRINTS  = 40;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic [7:0] PREFIX [4] = '{"x", "X", "b", "B"};

	typedef struct packed {
		logic [7:0] ch;
		logic       typed;   // tok holds the expected token, not the shadow's
		token_t     tok;
	} feed_item_t;

	localparam token_t NO_TOK = '0;

	localparam feed_item_t DIR_TAB [27] = '{
		'{CH_COLON, 1'b1, '{KIND_COLON,   16'd0, 16'd1, 16'd1, 1'b0, 1'b1}},
		'{CH_COMMA, 1'b1, '{KIND_COMMA,   16'd1, 16'd1, 16'd1, 1'b0, 1'b1}},
		'{CH_SEMI,  1'b1, '{KIND_SEMI,    16'd2, 16'd1, 16'd1, 1'b0, 1'b1}},
		'{8'hFF,    1'b1, '{KIND_UNKNOWN, 16'd3, 16'd1, 16'd1, 1'b0, 1'b1}},
		'{CH_NL,    1'b1, '{KIND_EOL,     16'd4, 16'd1, 16'd1, 1'b0, 1'b1}},
		'{CH_CR,    1'b0, NO_TOK},   // swallowed after newline
		'{CH_CR,    1'b0, NO_TOK},   // stray CR is unknown
		'{"a",      1'b0, NO_TOK},
		'{"9",      1'b0, NO_TOK},
		'{CH_SP,    1'b0, NO_TOK},
		'{CH_ZERO,  1'b0, NO_TOK},
		'{"x",      1'b0, NO_TOK},
		'{"Z",      1'b0, NO_TOK},   // hex with no digits, then symbol
		'{CH_COMMA, 1'b0, NO_TOK},   // two tokens
		'{CH_ZERO,  1'b0, NO_TOK},
		'{"B",      1'b0, NO_TOK},
		'{"1",      1'b0, NO_TOK},
		'{CH_NL,    1'b0, NO_TOK},
		'{CH_ZERO,  1'b0, NO_TOK},
		'{CH_SEMI,  1'b0, NO_TOK},   // lone zero is octal, empty body
		'{"7",      1'b0, NO_TOK},
		'{CH_DQ,    1'b0, NO_TOK},
		'{CH_NL,    1'b0, NO_TOK},   // no line count inside a string
		'{CH_DQ,    1'b0, NO_TOK},
		'{CH_SQ,    1'b0, NO_TOK},
		'{CH_NUL,   1'b0, NO_TOK},   // unclosed string flushed, then end
		'{CH_NUL,   1'b1, '{KIND_END,     16'd0, 16'd0, 16'd1, 1'b0, 1'b1}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	assembly_token_lexer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow lexer state
	mode_t       sh_mode = MODE_IDLE;
	kind_t       sh_kind = KIND_UNKNOWN;
	logic [15:0] sh_start = '0;
	logic [15:0] sh_pline = 16'd1;
	logic [15:0] sh_pos = '0;
	logic [15:0] sh_line = 16'd1;
	token_t      step_toks[$];

	feed_item_t  text_q[$];
	feed_item_t  cur_item;
	token_t      tok_expect[$];
	bit          offer_live = 1'b0;
	bit          moved;
	int          stall_cycles = 0;
	int          err_cnt = 0;
	int          tok_cnt = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	function automatic logic [15:0] sat_bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return c == CH_UNDER || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [15:0] body_len(input logic [15:0] p);
		return (p >= sh_start) ? p - sh_start : 16'd0;
	endfunction

	function automatic void add_tok(input kind_t k, input logic [15:0] s,
			input logic [15:0] l, input logic [15:0] ln, input logic unc);
		token_t t;
		t.kind = k;
		t.start = s;
		t.length = l;
		t.line = ln;
		t.unclosed = unc;
		t.last = 1'b0;
		step_toks.push_back(t);
	endfunction

	function automatic void lex_restart();
		sh_mode = MODE_IDLE;
		sh_kind = KIND_UNKNOWN;
		sh_start = '0;
		sh_pline = 16'd1;
		sh_pos = '0;
		sh_line = 16'd1;
	endfunction

	// character seen between tokens
	function automatic void lex_fresh(input logic [7:0] c, input logic [15:0] p);
		sh_mode = MODE_IDLE;
		if (c == CH_NL) begin
			add_tok(KIND_EOL, p, 16'd1, sh_line, 1'b0);
			sh_line = sat_bump(sh_line);
			sh_mode = MODE_AFTER_EOL;
		end else if (c == CH_COLON) begin
			add_tok(KIND_COLON, p, 16'd1, sh_line, 1'b0);
		end else if (c == CH_COMMA) begin
			add_tok(KIND_COMMA, p, 16'd1, sh_line, 1'b0);
		end else if (c == CH_SEMI) begin
			add_tok(KIND_SEMI, p, 16'd1, sh_line, 1'b0);
		end else if (c == CH_SQ || c == CH_DQ) begin
			sh_pline = sh_line;
			sh_mode = (c == CH_SQ) ? MODE_STR_SQ : MODE_STR_DQ;
			sh_kind = KIND_STRING;
			sh_start = sat_bump(p);
		end else if (is_alpha(c)) begin
			sh_pline = sh_line;
			sh_mode = MODE_SYMBOL;
			sh_kind = KIND_SYMBOL;
			sh_start = p;
		end else if (c == CH_ZERO) begin
			sh_pline = sh_line;
			sh_mode = MODE_ZERO;
			sh_kind = KIND_OCT;
			sh_start = sat_bump(p);
		end else if (is_digit(c)) begin
			sh_pline = sh_line;
			sh_mode = MODE_DIGITS;
			sh_kind = KIND_DEC;
			sh_start = p;
		end else if (c != CH_SP && c != CH_TAB) begin
			add_tok(KIND_UNKNOWN, p, 16'd1, sh_line, 1'b0);
		end
	endfunction

	// tokens caused by one accepted byte land in step_toks
	function automatic void lex_char(input logic [7:0] c);
		logic [15:0] p;
		p = sh_pos;
		step_toks.delete();
		if (c == CH_NUL) begin
			case (sh_mode)
				MODE_STR_SQ, MODE_STR_DQ: begin
					add_tok(KIND_STRING, sh_start, body_len(p), sh_pline, 1'b1);
				end
				MODE_SYMBOL, MODE_ZERO, MODE_DIGITS: begin
					add_tok(sh_kind, sh_start, body_len(p), sh_pline, 1'b0);
				end
				default: ;
			endcase
			add_tok(KIND_END, p, 16'd0, sh_line, 1'b0);
			lex_restart();
		end else begin
			case (sh_mode)
				MODE_AFTER_EOL: begin
					if (c == CH_CR)
						sh_mode = MODE_IDLE;
					else
						lex_fresh(c, p);
				end
				MODE_STR_SQ, MODE_STR_DQ: begin
					if (c == ((sh_mode == MODE_STR_SQ) ? CH_SQ : CH_DQ)) begin
						add_tok(KIND_STRING, sh_start, body_len(p), sh_pline, 1'b0);
						sh_mode = MODE_IDLE;
					end
				end
				MODE_SYMBOL: begin
					if (!(is_alpha(c) || is_digit(c))) begin
						add_tok(KIND_SYMBOL, sh_start, body_len(p), sh_pline, 1'b0);
						lex_fresh(c, p);
					end
				end
				MODE_ZERO: begin
					if (c == "b" || c == "B" || c == "x" || c == "X") begin
						sh_kind = (c == "b" || c == "B") ? KIND_BIN : KIND_HEX;
						sh_start = sat_bump(p);
						sh_mode = MODE_DIGITS;
					end else if (is_digit(c)) begin
						sh_mode = MODE_DIGITS;
					end else begin
						add_tok(KIND_OCT, sh_start, body_len(p), sh_pline, 1'b0);
						lex_fresh(c, p);
					end
				end
				MODE_DIGITS: begin
					if (!is_digit(c)) begin
						add_tok(sh_kind, sh_start, body_len(p), sh_pline, 1'b0);
						lex_fresh(c, p);
					end
				end
				default: lex_fresh(c, p);
			endcase
			sh_pos = sat_bump(p);
		end
		if (step_toks.size() != 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
	endfunction

	function automatic void push_ch(input logic [7:0] c);
		feed_item_t it;
		it = '0;
		it.ch = c;
		text_q.push_back(it);
	endfunction

	function automatic logic [7:0] rand_alpha();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'h41 + 8'(r);
		else if (r < 52)
			return 8'h61 + 8'(r - 26);
		else
			return CH_UNDER;
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// mostly assembly-shaped text with some raw noise mixed in
	function automatic void add_source_text(input int n_chars);
		int pick;
		int n;
		logic [7:0] q;
		while (text_q.size() < n_chars) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				push_ch(8'($urandom_range(1, 255)));
			end else if (pick < 9) begin
				push_ch(CH_NUL);
			end else if (pick < 24) begin
				push_ch(rand_alpha());
				n = $urandom_range(0, 6);
				repeat (n) push_ch(($urandom_range(0, 3) == 0) ? rand_digit() : rand_alpha());
			end else if (pick < 36) begin
				case ($urandom_range(0, 2))
					0: push_ch(CH_ZERO);
					1: begin
						push_ch(CH_ZERO);
						push_ch(PREFIX[$urandom_range(0, 3)]);
					end
					default: push_ch(CH_ZERO + 8'($urandom_range(1, 9)));
				endcase
				n = $urandom_range(0, 5);
				repeat (n) push_ch(rand_digit());
			end else if (pick < 44) begin
				q = ($urandom_range(0, 1) == 1) ? CH_DQ : CH_SQ;
				push_ch(q);
				n = $urandom_range(0, 8);
				repeat (n) push_ch(($urandom_range(0, 9) == 0) ? CH_NL :
					8'($urandom_range(32, 126)));
				if ($urandom_range(0, 9) != 0)
					push_ch(q);
			end else if (pick < 56) begin
				n = $urandom_range(1, 3);
				repeat (n) push_ch(($urandom_range(0, 1) == 1) ? CH_SP : CH_TAB);
			end else if (pick < 64) begin
				push_ch(CH_COMMA);
			end else if (pick < 70) begin
				push_ch(CH_COLON);
			end else if (pick < 75) begin
				push_ch(CH_SEMI);
			end else if (pick < 90) begin
				push_ch(CH_NL);
				if ($urandom_range(0, 1) == 1)
					push_ch(CH_CR);
			end else if (pick < 95) begin
				push_ch(CH_CR);
			end else begin
				push_ch(8'($urandom_range(32, 126)));
			end
		end
	endfunction

	task automatic report_err(input string what);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS)
			$display("mismatch at token %0d: %s", tok_cnt, what);
	endtask

	task automatic check_token();
		token_t want;
		if (tok_expect.size() == 0) begin
			report_err($sformatf("unexpected token, kind %0d", m_axis_tuser));
		end else begin
			want = tok_expect.pop_front();
			if (m_axis_tuser !== want.kind)
				report_err($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
			if (m_axis_tdata[15:0] !== want.start)
				report_err($sformatf("start %0d, want %0d", m_axis_tdata[15:0], want.start));
			if (m_axis_tdata[31:16] !== want.length)
				report_err($sformatf("length %0d, want %0d", m_axis_tdata[31:16],
					want.length));
			if (m_axis_tdata[47:32] !== want.line)
				report_err($sformatf("line %0d, want %0d", m_axis_tdata[47:32], want.line));
			if (m_axis_tdata[48] !== want.unclosed)
				report_err($sformatf("unclosed %b, want %b", m_axis_tdata[48], want.unclosed));
			if (m_axis_tdata[55:49] !== '0)
				report_err($sformatf("pad bits %h", m_axis_tdata[55:49]));
			if (m_axis_tlast !== want.last)
				report_err($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
		end
		tok_cnt++;
	endtask

	// input side, output check and watchdog share one process so that a byte
	// and the token it causes are ordered within an edge
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (offer_live && s_axis_tvalid && s_axis_tready) begin
				lex_char(cur_item.ch);
				if (cur_item.typed)
					tok_expect.push_back(cur_item.tok);
				else
					foreach (step_toks[i]) tok_expect.push_back(step_toks[i]);
				offer_live = 1'b0;
				moved = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				check_token();
				moved = 1'b1;
			end
			if (!offer_live) begin
				if (text_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					cur_item = text_q.pop_front();
					offer_live = 1'b1;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= cur_item.ch;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_assembly_token_lexer NOT OK");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic drain();
		while (text_q.size() != 0 || offer_live || tok_expect.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 17;
		rx_idle_pct = 77;
		foreach (DIR_TAB[i]) text_q.push_back(DIR_TAB[i]);
		drain();
		add_source_text(780);
		drain();

		tx_idle_pct = 77;
		rx_idle_pct = 17;
		add_source_text(780);
		drain();

		// full rate; long output stall first so the token queue backs up
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req++;
		add_source_text(110);
		push_ch(CH_NUL);
		drain();

		repeat (10) @(posedge clk);
		if (tok_expect.size() != 0)
			report_err($sformatf("%0d tokens never arrived", tok_expect.size()));
		if (err_cnt == 0)
			$display("tb_assembly_token_lexer OK");
		else
			$display("tb_assembly_token_lexer NOT OK");
		$finish;
	end

endmodule
